// File: src/rau_pkg.sv
// Package for the rational arithmetic unit: opcodes, status codes,
// beat types and the request and response types of the reduction engine.
// No dependencies.
`default_nettype none

package rau_pkg;

    localparam logic [63:0] MAX_MAG = 64'd2147483647;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NONINT   = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } rsp_t;

    // Sign-magnitude fraction handed to the reduction engine.
    typedef struct packed {
        logic [63:0] num_mag;
        logic [63:0] den_mag;
        logic        sign;
    } red_req_t;

    // Reduced fraction and its range flag.
    typedef struct packed {
        logic [63:0] num_mag;
        logic [63:0] den_mag;
        logic        sign;
        logic        ovf;
    } red_rsp_t;

endpackage

`default_nettype wire

// File: src/rau_reduce.sv
// Iterative fraction reduction engine: binary gcd, then exact division of
// numerator and denominator by the gcd with a restoring divider.
// Depends on rau_pkg.
`default_nettype none

module rau_reduce (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire rau_pkg::red_req_t req,
    output rau_pkg::red_rsp_t      rsp,
    output logic                   done
);

    typedef enum logic [5:0] {
        R_IDLE = 6'b000001,
        R_GCD  = 6'b000010,
        R_CHKG = 6'b000100,
        R_DIVN = 6'b001000,
        R_DIVD = 6'b010000,
        R_FIN  = 6'b100000
    } rstate_t;

    rstate_t           state_reg;
    logic [63:0]       n_reg, d_reg, x_reg, y_reg, g_reg;
    logic [63:0]       qn_reg, qd_reg, dv_reg, rem_reg;
    logic [5:0]        k_reg, cnt_reg;
    logic              sign_reg, done_reg;
    rau_pkg::red_rsp_t rsp_reg;

    logic [64:0] trial;
    logic        fits;
    logic [63:0] rem_step, dv_step;

    // One restoring division step per cycle.
    always_comb
    begin
        trial    = {rem_reg, dv_reg[63]};
        fits     = (trial >= {1'b0, g_reg});
        rem_step = fits ? 64'(trial - {1'b0, g_reg}) : trial[63:0];
        dv_step  = {dv_reg[62:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= req.num_mag;
                        d_reg     <= req.den_mag;
                        x_reg     <= req.num_mag;
                        y_reg     <= req.den_mag;
                        sign_reg  <= req.sign;
                        k_reg     <= 6'd0;
                        state_reg <= R_GCD;
                    end
                end
                R_GCD:
                begin
                    // The denominator is nonzero, so y never reaches zero.
                    if (x_reg == 64'd0)
                    begin
                        g_reg     <= y_reg << k_reg;
                        state_reg <= R_CHKG;
                    end
                    else if (!x_reg[0] && !y_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + 6'd1;
                    end
                    else if (!x_reg[0])
                        x_reg <= x_reg >> 1;
                    else if (!y_reg[0])
                        y_reg <= y_reg >> 1;
                    else if (x_reg >= y_reg)
                        x_reg <= (x_reg - y_reg) >> 1;
                    else
                        y_reg <= (y_reg - x_reg) >> 1;
                end
                R_CHKG:
                begin
                    if (g_reg == 64'd1)
                    begin
                        qn_reg    <= n_reg;
                        qd_reg    <= d_reg;
                        state_reg <= R_FIN;
                    end
                    else
                    begin
                        dv_reg    <= n_reg;
                        rem_reg   <= 64'd0;
                        cnt_reg   <= 6'd0;
                        state_reg <= R_DIVN;
                    end
                end
                R_DIVN:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        qn_reg    <= dv_step;
                        dv_reg    <= d_reg;
                        rem_reg   <= 64'd0;
                        state_reg <= R_DIVD;
                    end
                    else
                    begin
                        dv_reg  <= dv_step;
                        rem_reg <= rem_step;
                    end
                end
                R_DIVD:
                begin
                    dv_reg  <= dv_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        qd_reg    <= dv_step;
                        state_reg <= R_FIN;
                    end
                end
                R_FIN:
                begin
                    rsp_reg.num_mag <= qn_reg;
                    rsp_reg.den_mag <= qd_reg;
                    rsp_reg.sign    <= sign_reg && (qn_reg != 64'd0);
                    rsp_reg.ovf     <= (qn_reg > rau_pkg::MAX_MAG) ||
                                       (qd_reg > rau_pkg::MAX_MAG);
                    done_reg        <= 1'b1;
                    state_reg       <= R_IDLE;
                end
                default:
                    state_reg <= R_IDLE;
            endcase
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: command sequencer, shared
// multiplier and the fraction reduction engine.
// Depends on rau_pkg and rau_reduce.
`default_nettype none

// A command beat is taken when start is high and busy is low. The unit then
// stays busy until its single result beat appears on response, marked by
// done for exactly one cycle; the receiver cannot stall it, so it must take
// the beat in that cycle. The response register holds its value until the
// next result, and a new command may be started in the same cycle as done.
// Latency is set by the reduction engine, which both operands and the
// combined products pass through: each reduction runs one binary gcd step
// at a time (at most about 130 steps) and then, when the gcd is not one,
// divides numerator and denominator. Add, subtract, multiply and divide take
// three reductions. Integer power takes two reductions plus up to two per
// exponent bit, so up to about 64 reductions. Unused opcodes and zero
// operand denominators answer without a reduction.

module rational_arithmetic_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rau_pkg::req_t request,
    output logic               busy,
    output logic               done,
    output rau_pkg::rsp_t      response
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_CHK      = 13'b0000000000010,
        S_RED_WAIT = 13'b0000000000100,
        S_OPSEL    = 13'b0000000001000,
        S_M1       = 13'b0000000010000,
        S_M2       = 13'b0000000100000,
        S_M3       = 13'b0000001000000,
        S_COMB     = 13'b0000010000000,
        S_PW_CHK   = 13'b0000100000000,
        S_PW_M1    = 13'b0001000000000,
        S_PW_M2    = 13'b0010000000000,
        S_PW_SHIFT = 13'b0100000000000,
        S_SPARE    = 13'b1000000000000
    } state_t;

    // What the pending reduction result is for.
    typedef enum logic [4:0] {
        TAG_A   = 5'b00001,
        TAG_B   = 5'b00010,
        TAG_RES = 5'b00100,
        TAG_R   = 5'b01000,
        TAG_P   = 5'b10000
    } tag_t;

    state_t            state_reg;
    tag_t              tag_reg;
    logic [2:0]        op_reg;
    logic              an_s_reg, bn_s_reg, r_s_reg, p_s_reg, sq_reg, ovf_ab_reg;
    logic [31:0]       an_m_reg, ad_reg, bn_m_reg, bd_reg;
    logic [31:0]       r_num_reg, r_den_reg, p_num_reg, p_den_reg;
    logic [30:0]       e_reg;
    logic [63:0]       p1_reg, p2_reg, p3_reg;
    logic              done_reg, red_start_reg;
    rau_pkg::red_req_t rq_reg;
    rau_pkg::rsp_t     rsp_reg;

    rau_pkg::red_rsp_t red_rsp;
    logic              red_done;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        s2;
    logic [63:0] sum_mag;
    logic        sum_sign;

    rau_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start_reg),
        .req   (rq_reg),
        .rsp   (red_rsp),
        .done  (red_done)
    );

    // Build a result beat; a failed status always carries 0/1.
    function automatic rau_pkg::rsp_t make_rsp(input logic sign, input logic [31:0] mag,
                                               input logic [30:0] den, input logic [1:0] st);
        rau_pkg::rsp_t r;
        if (st != rau_pkg::ST_OK)
        begin
            r.res_num = 32'sd0;
            r.res_den = 31'd1;
        end
        else
        begin
            r.res_num = sign ? -$signed(mag) : $signed(mag);
            r.res_den = den;
        end
        r.status = st;
        return r;
    endfunction

    // The single shared multiplier; its product is always registered.
    always_comb
    begin
        case (state_reg)
            S_M1:
            begin
                mul_a = an_m_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? bn_m_reg : bd_reg;
            end
            S_M2:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == rau_pkg::OP_MUL) ? bd_reg : bn_m_reg;
            end
            S_M3:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            S_PW_M1:
            begin
                mul_a = sq_reg ? p_num_reg : r_num_reg;
                mul_b = p_num_reg;
            end
            S_PW_M2:
            begin
                mul_a = sq_reg ? p_den_reg : r_den_reg;
                mul_b = p_den_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Signed sum of the two cross products for add and subtract.
    always_comb
    begin
        s2 = bn_s_reg ^ (op_reg == rau_pkg::OP_SUB);
        if (an_s_reg == s2)
        begin
            sum_mag  = p1_reg + p2_reg;
            sum_sign = an_s_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_mag  = p1_reg - p2_reg;
            sum_sign = an_s_reg;
        end
        else
        begin
            sum_mag  = p2_reg - p1_reg;
            sum_sign = s2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            red_start_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            red_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= request.opcode;
                        an_s_reg  <= request.a_num[31];
                        an_m_reg  <= request.a_num[31] ? 32'(-request.a_num) : request.a_num;
                        ad_reg    <= {1'b0, request.a_den};
                        bn_s_reg  <= request.b_num[31];
                        bn_m_reg  <= request.b_num[31] ? 32'(-request.b_num) : request.b_num;
                        bd_reg    <= {1'b0, request.b_den};
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (op_reg > rau_pkg::OP_POW)
                    begin
                        rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1, rau_pkg::ST_OK);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (ad_reg == 32'd0 || bd_reg == 32'd0)
                    begin
                        rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1, rau_pkg::ST_DIVZERO);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        rq_reg.num_mag <= {32'd0, an_m_reg};
                        rq_reg.den_mag <= {32'd0, ad_reg};
                        rq_reg.sign    <= an_s_reg;
                        tag_reg        <= TAG_A;
                        red_start_reg  <= 1'b1;
                        state_reg      <= S_RED_WAIT;
                    end
                end
                S_RED_WAIT:
                begin
                    if (red_done)
                    begin
                        case (tag_reg)
                            TAG_A:
                            begin
                                an_s_reg       <= red_rsp.sign;
                                an_m_reg       <= red_rsp.num_mag[31:0];
                                ad_reg         <= red_rsp.den_mag[31:0];
                                ovf_ab_reg     <= red_rsp.ovf;
                                rq_reg.num_mag <= {32'd0, bn_m_reg};
                                rq_reg.den_mag <= {32'd0, bd_reg};
                                rq_reg.sign    <= bn_s_reg;
                                tag_reg        <= TAG_B;
                                red_start_reg  <= 1'b1;
                            end
                            TAG_B:
                            begin
                                bn_s_reg <= red_rsp.sign;
                                bn_m_reg <= red_rsp.num_mag[31:0];
                                bd_reg   <= red_rsp.den_mag[31:0];
                                if (ovf_ab_reg || red_rsp.ovf)
                                begin
                                    rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1,
                                                          rau_pkg::ST_OVERFLOW);
                                    done_reg  <= 1'b1;
                                    state_reg <= S_IDLE;
                                end
                                else
                                    state_reg <= S_OPSEL;
                            end
                            TAG_RES:
                            begin
                                rsp_reg   <= make_rsp(red_rsp.sign, red_rsp.num_mag[31:0],
                                                      red_rsp.den_mag[30:0],
                                                      red_rsp.ovf ? rau_pkg::ST_OVERFLOW
                                                                  : rau_pkg::ST_OK);
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            TAG_R:
                            begin
                                r_s_reg   <= red_rsp.sign;
                                r_num_reg <= red_rsp.num_mag[31:0];
                                r_den_reg <= red_rsp.den_mag[31:0];
                                if (red_rsp.ovf)
                                begin
                                    rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1,
                                                          rau_pkg::ST_OVERFLOW);
                                    done_reg  <= 1'b1;
                                    state_reg <= S_IDLE;
                                end
                                else
                                    state_reg <= S_PW_SHIFT;
                            end
                            TAG_P:
                            begin
                                p_s_reg   <= red_rsp.sign;
                                p_num_reg <= red_rsp.num_mag[31:0];
                                p_den_reg <= red_rsp.den_mag[31:0];
                                if (red_rsp.ovf)
                                begin
                                    rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1,
                                                          rau_pkg::ST_OVERFLOW);
                                    done_reg  <= 1'b1;
                                    state_reg <= S_IDLE;
                                end
                                else
                                    state_reg <= S_PW_CHK;
                            end
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_OPSEL:
                begin
                    if (op_reg == rau_pkg::OP_POW)
                    begin
                        // Reduced operands: B is an integer exactly when its
                        // denominator is one.
                        r_s_reg   <= 1'b0;
                        r_num_reg <= 32'd1;
                        r_den_reg <= 32'd1;
                        e_reg     <= bn_m_reg[30:0];
                        if (bd_reg != 32'd1)
                        begin
                            rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1, rau_pkg::ST_NONINT);
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (bn_s_reg)
                        begin
                            // A negative exponent inverts the base; a reduced
                            // base inverts without another reduction.
                            if (an_m_reg == 32'd0)
                            begin
                                rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1,
                                                      rau_pkg::ST_DIVZERO);
                                done_reg  <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                p_s_reg   <= an_s_reg;
                                p_num_reg <= ad_reg;
                                p_den_reg <= an_m_reg;
                                state_reg <= S_PW_CHK;
                            end
                        end
                        else
                        begin
                            p_s_reg   <= an_s_reg;
                            p_num_reg <= an_m_reg;
                            p_den_reg <= ad_reg;
                            state_reg <= S_PW_CHK;
                        end
                    end
                    else if (op_reg == rau_pkg::OP_DIV && bn_m_reg == 32'd0)
                    begin
                        rsp_reg   <= make_rsp(1'b0, 32'd0, 31'd1, rau_pkg::ST_DIVZERO);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_M1;
                end
                S_M1:
                begin
                    p1_reg    <= prod;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    p2_reg <= prod;
                    if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB)
                        state_reg <= S_M3;
                    else
                        state_reg <= S_COMB;
                end
                S_M3:
                begin
                    p3_reg    <= prod;
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB)
                    begin
                        rq_reg.num_mag <= sum_mag;
                        rq_reg.den_mag <= p3_reg;
                        rq_reg.sign    <= sum_sign;
                    end
                    else
                    begin
                        rq_reg.num_mag <= p1_reg;
                        rq_reg.den_mag <= p2_reg;
                        rq_reg.sign    <= an_s_reg ^ bn_s_reg;
                    end
                    tag_reg       <= TAG_RES;
                    red_start_reg <= 1'b1;
                    state_reg     <= S_RED_WAIT;
                end
                S_PW_CHK:
                begin
                    if (e_reg == 31'd0)
                    begin
                        rsp_reg   <= make_rsp(r_s_reg, r_num_reg, r_den_reg[30:0],
                                              rau_pkg::ST_OK);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (e_reg[0])
                    begin
                        sq_reg    <= 1'b0;
                        state_reg <= S_PW_M1;
                    end
                    else
                        state_reg <= S_PW_SHIFT;
                end
                S_PW_M1:
                begin
                    p1_reg    <= prod;
                    state_reg <= S_PW_M2;
                end
                S_PW_M2:
                begin
                    rq_reg.num_mag <= p1_reg;
                    rq_reg.den_mag <= prod;
                    rq_reg.sign    <= sq_reg ? 1'b0 : (r_s_reg ^ p_s_reg);
                    tag_reg        <= sq_reg ? TAG_P : TAG_R;
                    red_start_reg  <= 1'b1;
                    state_reg      <= S_RED_WAIT;
                end
                S_PW_SHIFT:
                begin
                    // The squaring after the last exponent bit is skipped.
                    e_reg <= e_reg >> 1;
                    if ((e_reg >> 1) != 31'd0)
                    begin
                        sq_reg    <= 1'b1;
                        state_reg <= S_PW_M1;
                    end
                    else
                    begin
                        rsp_reg   <= make_rsp(r_s_reg, r_num_reg, r_den_reg[30:0],
                                              rau_pkg::ST_OK);
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

`default_nettype wire
